// ===== hdl/pimw_pkg.sv =====
// pimw_pkg: shared types and constants for the point-in-multipolygon block
// holds the transaction structs, operation and location codes, sequencer states
// no dependencies
package pimw_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_INSIDE   = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;

    // rings shorter than this are dropped when finalized
    localparam int MIN_RING_LEN = 4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               ring_begin;
        logic               polygon_begin;
    } req_t;

    typedef struct packed {
        logic [1:0] location;
        logic       overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POLY,
        ST_PWAIT,
        ST_RING,
        ST_RWAIT,
        ST_EDGE,
        ST_DRAIN,
        ST_NEXT
    } state_t;

endpackage

// ===== hdl/point_in_multipolygon_winding.sv =====
// point_in_multipolygon_winding: ring store plus winding-number query sequencer
// holds vertex, ring and polygon stores and one pipelined cross-product unit
// depends on pimw_pkg
// Clear and load are completed in the idle state; their response is registered.
// A query walks the polygons and their rings; the single read port of the vertex store
// feeds one vertex per cycle into the cross-product pipeline.
// One transaction is in work at a time. Reset clears all counts; stores are not cleared.
module point_in_multipolygon_winding
    import pimw_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_RINGS    = 256,
    parameter int MAX_POLYGONS = 64,
    parameter int COORD_BITS   = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int VCW = VIW + 1;
    localparam int RIW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int RCW = RIW + 1;
    localparam int PIW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
    localparam int PCW = PIW + 1;
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int MW  = 2 * DW;
    localparam int WW  = VIW + 2;

    // stores
    logic signed [CB-1:0] vx_mem [MAX_VERTICES];
    logic signed [CB-1:0] vy_mem [MAX_VERTICES];
    logic [VIW-1:0]       rf_mem [MAX_RINGS];
    logic [VCW-1:0]       rt_mem [MAX_RINGS];
    logic [RCW-1:0]       pt_mem [MAX_POLYGONS];

    logic signed [CB-1:0] vx_q, vy_q;
    logic [VIW-1:0]       rf_q;
    logic [VCW-1:0]       rt_q;
    logic [RCW-1:0]       pt_q;

    // control registers
    state_t state_reg, state_next;
    logic [VCW-1:0] vc_reg, vc_next;
    logic [RCW-1:0] rc_reg, rc_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [VCW-1:0] open_reg, open_next;
    logic [RCW-1:0] cur_reg, cur_next;
    logic signed [CB-1:0] px_reg, px_next, py_reg, py_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [RCW-1:0] i_reg, i_next, r_reg, r_next, n_reg, n_next;
    logic [VCW-1:0] k_reg, k_next, kend_reg, kend_next;
    logic           first_reg, first_next;
    logic [1:0]     res_reg, res_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    // pipeline
    logic                 s1_v_reg, s1_first_reg;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg;
    logic                 s2_v_reg, s2_box_reg, s2_up_reg, s2_dn_reg;
    logic signed [DW-1:0] s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg;
    logic                 s3_v_reg, s3_box_reg, s3_up_reg, s3_dn_reg, s3_n1_reg, s3_n2_reg;
    logic [MW-1:0]        s3_m1_reg, s3_m2_reg;
    logic signed [WW-1:0] wind_reg;
    logic                 bnd_reg;

    // comb control
    logic                 acc;
    logic                 starts_poly, starts_ring, ovf, fin_do, fin_keep;
    logic [VCW-1:0]       vc_fin, ring_start;
    logic [RCW-1:0]       cur_fin, ir, n_val;
    logic [PCW-1:0]       pc_m1;
    logic [VCW:0]         rend;
    logic                 vw_en, rw_en, pw_en, vrd_en, vrd_first, prd_en, edge_init;
    logic signed [CB-1:0] in_x, in_y;

    assign acc       = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign in_x       = req.x[CB-1:0];
    assign in_y       = req.y[CB-1:0];
    assign pc_m1      = pc_reg - PCW'(1);
    assign ring_start = vc_reg - open_reg;
    assign ir         = i_reg + r_reg;
    assign rend       = {1'b0, VCW'(rf_q)} + {1'b0, rt_q};

    // load admission and ring finalize
    always_comb
    begin
        starts_poly = req.polygon_begin || (pc_reg == '0);
        starts_ring = req.ring_begin || starts_poly || (open_reg == '0);
        ovf = (starts_poly && (pc_reg >= PCW'(MAX_POLYGONS)))
           || (vc_reg >= VCW'(MAX_VERTICES))
           || (starts_ring
               && ((rc_reg + RCW'(open_reg >= VCW'(MIN_RING_LEN))) >= RCW'(MAX_RINGS)));
        if (req.op == OP_QUERY)
            fin_do = (open_reg != '0);
        else
            fin_do = (req.op == OP_LOAD) && starts_ring && !ovf && (open_reg != '0);
        fin_keep = fin_do && (open_reg >= VCW'(MIN_RING_LEN))
                && (rc_reg < RCW'(MAX_RINGS)) && (pc_reg != '0);
        vc_fin  = (fin_do && !fin_keep) ? ring_start : vc_reg;
        cur_fin = cur_reg + RCW'(fin_keep);
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        vc_next        = vc_reg;
        rc_next        = rc_reg;
        pc_next        = pc_reg;
        open_next      = open_reg;
        cur_next       = cur_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        kend_next      = kend_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        vw_en          = 1'b0;
        rw_en          = 1'b0;
        pw_en          = 1'b0;
        vrd_en         = 1'b0;
        vrd_first      = 1'b0;
        prd_en         = 1'b0;
        edge_init      = 1'b0;
        n_val          = (p_reg == pc_m1) ? cur_reg : pt_q;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    rsp_next = '{location: LOC_OUTSIDE, overflow: 1'b0};
                    case (req.op)
                        OP_CLEAR:
                        begin
                            vc_next        = '0;
                            rc_next        = '0;
                            pc_next        = '0;
                            open_next      = '0;
                            cur_next       = '0;
                            rsp_valid_next = 1'b1;
                        end
                        OP_LOAD:
                        begin
                            rsp_valid_next    = 1'b1;
                            rsp_next.overflow = ovf;
                            if (!ovf)
                            begin
                                rw_en     = fin_keep;
                                rc_next   = rc_reg + RCW'(fin_keep);
                                vw_en     = 1'b1;
                                vc_next   = vc_fin + VCW'(1);
                                open_next = starts_ring ? VCW'(1) : open_reg + VCW'(1);
                                if (starts_poly)
                                begin
                                    pw_en    = (pc_reg != '0);
                                    pc_next  = pc_reg + PCW'(1);
                                    cur_next = '0;
                                end
                                else
                                begin
                                    cur_next = cur_fin;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            rw_en      = fin_keep;
                            rc_next    = rc_reg + RCW'(fin_keep);
                            cur_next   = cur_fin;
                            vc_next    = vc_fin;
                            open_next  = '0;
                            px_next    = in_x;
                            py_next    = in_y;
                            p_next     = '0;
                            i_next     = '0;
                            state_next = ST_POLY;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POLY:
            begin
                if (p_reg >= pc_reg)
                begin
                    rsp_next       = '{location: LOC_OUTSIDE, overflow: 1'b0};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    prd_en     = 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                if (n_val == '0)
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_POLY;
                end
                else
                begin
                    n_next     = n_val;
                    r_next     = '0;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if ((ir >= rc_reg) || (rt_q < VCW'(2)) || (rend > {1'b0, vc_reg}))
                begin
                    res_next   = LOC_OUTSIDE;
                    state_next = ST_NEXT;
                end
                else
                begin
                    k_next     = VCW'(rf_q);
                    kend_next  = rend[VCW-1:0];
                    first_next = 1'b1;
                    edge_init  = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                vrd_en     = 1'b1;
                vrd_first  = first_reg;
                first_next = 1'b0;
                k_next     = k_reg + VCW'(1);
                if (k_reg + VCW'(1) == kend_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    if (bnd_reg)
                        res_next = LOC_BOUNDARY;
                    else if (wind_reg != '0)
                        res_next = LOC_INSIDE;
                    else
                        res_next = LOC_OUTSIDE;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (res_reg == LOC_BOUNDARY)
                begin
                    rsp_next       = '{location: LOC_BOUNDARY, overflow: 1'b0};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if ((r_reg == '0) ? (res_reg != LOC_INSIDE) : (res_reg == LOC_INSIDE))
                begin
                    // outside the exterior, or inside a hole: next polygon
                    i_next     = i_reg + n_reg;
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_POLY;
                end
                else if (r_reg + RCW'(1) < n_reg)
                begin
                    r_next     = r_reg + RCW'(1);
                    state_next = ST_RING;
                end
                else
                begin
                    rsp_next       = '{location: LOC_INSIDE, overflow: 1'b0};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vc_reg        <= '0;
            rc_reg        <= '0;
            pc_reg        <= '0;
            open_reg      <= '0;
            cur_reg       <= '0;
            p_reg         <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            kend_reg      <= '0;
            first_reg     <= 1'b0;
            res_reg       <= LOC_OUTSIDE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            rc_reg        <= rc_next;
            pc_reg        <= pc_next;
            open_reg      <= open_next;
            cur_reg       <= cur_next;
            p_reg         <= p_next;
            i_reg         <= i_next;
            r_reg         <= r_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            kend_reg      <= kend_next;
            first_reg     <= first_next;
            res_reg       <= res_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        rsp_reg <= rsp_next;
    end

    // vertex store, at most one write and one read per cycle
    always_ff @(posedge clk)
    begin
        if (vw_en)
        begin
            vx_mem[vc_fin[VIW-1:0]] <= in_x;
            vy_mem[vc_fin[VIW-1:0]] <= in_y;
        end
        vx_q <= vx_mem[k_reg[VIW-1:0]];
        vy_q <= vy_mem[k_reg[VIW-1:0]];
    end

    // ring store
    always_ff @(posedge clk)
    begin
        if (rw_en)
        begin
            rf_mem[rc_reg[RIW-1:0]] <= ring_start[VIW-1:0];
            rt_mem[rc_reg[RIW-1:0]] <= open_reg;
        end
        rf_q <= rf_mem[ir[RIW-1:0]];
        rt_q <= rt_mem[ir[RIW-1:0]];
    end

    // polygon store, written with the final ring count when the next polygon opens
    always_ff @(posedge clk)
    begin
        if (pw_en)
            pt_mem[pc_m1[PIW-1:0]] <= cur_fin;
        if (prd_en)
            pt_q <= pt_mem[p_reg[PIW-1:0]];
    end

    // edge pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
        end
        else
        begin
            s1_v_reg     <= vrd_en;
            s1_first_reg <= vrd_first;
            s2_v_reg     <= s1_v_reg && !s1_first_reg
                         && !((prev_x_reg == vx_q) && (prev_y_reg == vy_q));
            s3_v_reg     <= s2_v_reg;
        end
    end

    // edge stage: differences and range flags
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            prev_x_reg <= vx_q;
            prev_y_reg <= vy_q;
        end
        s2_a_reg   <= {vx_q[CB-1], vx_q} - {prev_x_reg[CB-1], prev_x_reg};
        s2_b_reg   <= {py_reg[CB-1], py_reg} - {prev_y_reg[CB-1], prev_y_reg};
        s2_c_reg   <= {px_reg[CB-1], px_reg} - {prev_x_reg[CB-1], prev_x_reg};
        s2_d_reg   <= {vy_q[CB-1], vy_q} - {prev_y_reg[CB-1], prev_y_reg};
        s2_box_reg <= (px_reg >= ((prev_x_reg < vx_q) ? prev_x_reg : vx_q))
                   && (px_reg <= ((prev_x_reg > vx_q) ? prev_x_reg : vx_q))
                   && (py_reg >= ((prev_y_reg < vy_q) ? prev_y_reg : vy_q))
                   && (py_reg <= ((prev_y_reg > vy_q) ? prev_y_reg : vy_q));
        s2_up_reg  <= (prev_y_reg <= py_reg) && (py_reg < vy_q);
        s2_dn_reg  <= (vy_q <= py_reg) && (py_reg < prev_y_reg);
    end

    // multiply stage: magnitude products and their signs
    always_ff @(posedge clk)
    begin
        s3_m1_reg  <= MW'(s2_a_reg[DW-1] ? -s2_a_reg : s2_a_reg)
                    * MW'(s2_b_reg[DW-1] ? -s2_b_reg : s2_b_reg);
        s3_m2_reg  <= MW'(s2_c_reg[DW-1] ? -s2_c_reg : s2_c_reg)
                    * MW'(s2_d_reg[DW-1] ? -s2_d_reg : s2_d_reg);
        s3_n1_reg  <= (s2_a_reg != '0) && (s2_b_reg != '0) && (s2_a_reg[DW-1] ^ s2_b_reg[DW-1]);
        s3_n2_reg  <= (s2_c_reg != '0) && (s2_d_reg != '0) && (s2_c_reg[DW-1] ^ s2_d_reg[DW-1]);
        s3_box_reg <= s2_box_reg;
        s3_up_reg  <= s2_up_reg;
        s3_dn_reg  <= s2_dn_reg;
    end

    // compare stage: side of edge, winding and boundary update
    logic side_pos, side_neg;
    always_comb
    begin
        side_pos = (!s3_n1_reg && s3_n2_reg)
                || (!s3_n1_reg && !s3_n2_reg && (s3_m1_reg > s3_m2_reg))
                || (s3_n1_reg && s3_n2_reg && (s3_m2_reg > s3_m1_reg));
        side_neg = (s3_n1_reg && !s3_n2_reg)
                || (!s3_n1_reg && !s3_n2_reg && (s3_m1_reg < s3_m2_reg))
                || (s3_n1_reg && s3_n2_reg && (s3_m2_reg < s3_m1_reg));
    end

    always_ff @(posedge clk)
    begin
        if (edge_init)
        begin
            wind_reg <= '0;
            bnd_reg  <= 1'b0;
        end
        else if (s3_v_reg)
        begin
            if (!side_pos && !side_neg && s3_box_reg)
                bnd_reg <= 1'b1;
            else if (s3_up_reg && side_pos)
                wind_reg <= wind_reg + WW'(1);
            else if (s3_dn_reg && side_neg)
                wind_reg <= wind_reg - WW'(1);
        end
    end

    // checks
    a_ovf_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.overflow && (rsp.location != LOC_OUTSIDE)))
        else $error("overflow flagged together with a location");
    a_open_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg >= open_reg)
        else $error("open ring longer than stored vertices");
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_v_reg && !s2_v_reg && !s3_v_reg))
        else $error("edge pipeline busy while idle");
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RCW'(MAX_RINGS))
        else $error("ring count beyond store depth");

endmodule

// ===== verif/pimw_checker.sv =====
// pimw_checker: watches both channels, predicts each response and compares
// depends on pimw_pkg; keeps its own copy of the ring, polygon and vertex stores
module pimw_checker
    import pimw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending_count
);

    localparam int NV = 4096;
    localparam int NR = 256;
    localparam int NP = 64;

    logic signed [31:0] vx [NV];
    logic signed [31:0] vy [NV];
    int unsigned ring_first [NR];
    int unsigned ring_len [NR];
    int unsigned poly_rings [NP];
    int unsigned n_vert, n_ring, n_poly, open_len;
    rsp_t expected_rsp [$];

    // close the open ring, dropping it if it is too short, the ring store is full or no polygon is open
    function automatic void close_ring();
        if (open_len == 0) return;
        if (open_len >= MIN_RING_LEN && n_ring < NR && n_poly > 0)
        begin
            ring_first[n_ring] = n_vert - open_len;
            ring_len[n_ring] = open_len;
            n_ring++;
            poly_rings[n_poly - 1]++;
        end
        else
        begin
            n_vert -= open_len;
        end
        open_len = 0;
    endfunction

    // winding test of one ring: outside, inside or boundary
    function automatic logic [1:0] ring_location(int unsigned r, longint px, longint py);
        int wind;
        int unsigned f;
        int unsigned n;
        longint x1, y1, x2, y2, lhs;
        wind = 0;
        if (r >= n_ring) return LOC_OUTSIDE;
        f = ring_first[r];
        n = ring_len[r];
        if (n < 2 || f + n > n_vert) return LOC_OUTSIDE;
        for (int unsigned k = f; k + 1 < f + n; k++)
        begin
            x1 = vx[k]; y1 = vy[k]; x2 = vx[k + 1]; y2 = vy[k + 1];
            if (x1 == x2 && y1 == y2) continue;
            // products fit in 66 bits; compare as 128-bit signed
            begin
                logic signed [127:0] c1, c2;
                c1 = 128'(signed'(x2 - x1)) * 128'(signed'(py - y1));
                c2 = 128'(signed'(px - x1)) * 128'(signed'(y2 - y1));
                lhs = (c1 > c2) ? 1 : ((c1 < c2) ? -1 : 0);
            end
            if (lhs == 0 && px >= (x1 < x2 ? x1 : x2) && px <= (x1 > x2 ? x1 : x2)
                && py >= (y1 < y2 ? y1 : y2) && py <= (y1 > y2 ? y1 : y2))
                return LOC_BOUNDARY;
            if (y1 <= py && py < y2 && lhs > 0) wind++;
            else if (y2 <= py && py < y1 && lhs < 0) wind--;
        end
        return (wind != 0) ? LOC_INSIDE : LOC_OUTSIDE;
    endfunction

    function automatic logic [1:0] locate_point(longint px, longint py);
        int unsigned base;
        logic [1:0] res;
        logic in_hole;
        base = 0;
        close_ring();
        for (int unsigned p = 0; p < n_poly; p++)
        begin
            if (poly_rings[p] == 0) continue;
            res = ring_location(base, px, py);
            if (res == LOC_BOUNDARY) return LOC_BOUNDARY;
            if (res == LOC_INSIDE)
            begin
                in_hole = 1'b0;
                for (int unsigned r = 1; r < poly_rings[p]; r++)
                begin
                    res = ring_location(base + r, px, py);
                    if (res == LOC_BOUNDARY) return LOC_BOUNDARY;
                    if (res == LOC_INSIDE)
                    begin
                        in_hole = 1'b1;
                        break;
                    end
                end
                if (!in_hole) return LOC_INSIDE;
            end
            base += poly_rings[p];
        end
        return LOC_OUTSIDE;
    endfunction

    // store one vertex; returns 1 when a store is full
    function automatic logic store_vertex(req_t t);
        logic new_poly;
        logic new_ring;
        new_poly = t.polygon_begin || n_poly == 0;
        new_ring = t.ring_begin || new_poly || open_len == 0;
        if (new_poly && n_poly >= NP) return 1'b1;
        if (n_vert >= NV) return 1'b1;
        if (new_ring)
        begin
            if (n_ring + (open_len >= MIN_RING_LEN ? 1 : 0) >= NR) return 1'b1;
            close_ring();
        end
        if (new_poly)
        begin
            poly_rings[n_poly] = 0;
            n_poly++;
        end
        vx[n_vert] = t.x;
        vy[n_vert] = t.y;
        n_vert++;
        open_len++;
        return 1'b0;
    endfunction

    function automatic rsp_t predict_response(req_t t);
        rsp_t r;
        r = '0;
        case (t.op)
            OP_CLEAR:
            begin
                n_vert = 0; n_ring = 0; n_poly = 0; open_len = 0;
            end
            OP_LOAD:  r.overflow = store_vertex(t);
            OP_QUERY: r.location = locate_point(t.x, t.y);
            default: ;
        endcase
        return r;
    endfunction

    // sample accepted transactions on both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vert = 0; n_ring = 0; n_poly = 0; open_len = 0;
            expected_rsp.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    if (e.location !== rsp.location || e.overflow !== rsp.overflow)
                    begin
                        $display("%0t: mismatch expected loc=%0d ovf=%0d actual loc=%0d ovf=%0d",
                                 $time, e.location, e.overflow, rsp.location, rsp.overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp.push_back(predict_response(req));
            pending_count <= expected_rsp.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// tb: stimulus and verdict for point_in_multipolygon_winding
// depends on pimw_pkg, the block and pimw_checker
module tb;
    import pimw_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;
    int   stall_left = 0;

    always #4 clk = ~clk;

    point_in_multipolygon_winding u_top (.*);

    pimw_checker u_chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one transaction and wait for acceptance; valid stays high into a zero gap
    task automatic send(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                        logic rb, logic pb);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{op: op, x: x, y: y, ring_begin: rb, polygon_begin: pb};
        do @(posedge clk); while (req_stall);
    endtask

    // a closed square ring; first vertex may start a polygon
    task automatic square(int cx, int cy, int h, logic pb);
        send(OP_LOAD, cx - h, cy - h, 1'b1, pb);
        send(OP_LOAD, cx + h, cy - h, 1'b0, 1'b0);
        send(OP_LOAD, cx + h, cy + h, 1'b0, 1'b0);
        send(OP_LOAD, cx - h, cy + h, 1'b0, 1'b0);
        send(OP_LOAD, cx - h, cy - h, 1'b0, 1'b0);
    endtask

    // random response stall, mostly short with a few long bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(10, 40);
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 9) < 3);
        end
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int c, h;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, hole, boundary, short ring, unused op, clear
        send(OP_QUERY, 0, 0, 1'b0, 1'b0);
        square(0, 0, 100, 1'b1);
        square(0, 0, 20, 1'b0);
        send(OP_LOAD, 500, 500, 1'b1, 1'b0);
        send(OP_LOAD, 500, 500, 1'b0, 1'b0);
        send(OP_QUERY, 50, 0, 1'b0, 1'b0);
        send(OP_QUERY, 0, 0, 1'b0, 1'b0);
        send(OP_QUERY, 100, 5, 1'b0, 1'b0);
        send(OP_QUERY, 20, 20, 1'b0, 1'b0);
        send(OP_QUERY, 300, 0, 1'b0, 1'b0);
        send(OP_UNUSED, -1, -1, 1'b1, 1'b1);
        send(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b1);
        send(OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 1'b0);
        send(OP_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 1'b0);
        send(OP_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 1'b0);
        send(OP_LOAD, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0, 1'b0);
        send(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
        send(OP_QUERY, 32'sh7fff_fff0, 0, 1'b0, 1'b0);
        send(OP_QUERY, 32'sh8000_0000, 5, 1'b0, 1'b0);
        send(OP_QUERY, -1, -1, 1'b0, 1'b0);
        send(OP_CLEAR, 0, 0, 1'b0, 1'b0);
        // overflow of the polygon store: 66 one-vertex polygons
        for (int i = 0; i < 66; i++) send(OP_LOAD, i, i, 1'b1, 1'b1);
        send(OP_QUERY, 0, 0, 1'b0, 1'b0);
        send(OP_CLEAR, 0, 0, 1'b0, 1'b0);
        // random: mostly well-formed squares with queries, some noise
        for (int i = 0; i < 6; i++)
        begin
            if ($urandom_range(0, 5) == 0) send(OP_CLEAR, 0, 0, 1'b0, 1'b0);
            c = $urandom_range(0, 200) - 100;
            h = $urandom_range(1, 60);
            square(c, c, h, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                send(OP_LOAD, $urandom, $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            repeat (2) send(OP_QUERY, $urandom_range(0, 400) - 200,
                            $urandom_range(0, 400) - 200, 1'b0, 1'b0);
            if ($urandom_range(0, 4) == 0) send(OP_QUERY, $urandom, $urandom, 1'b1, 1'b1);
        end
        req_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pimw_pkg.sv
hdl/point_in_multipolygon_winding.sv
verif/pimw_checker.sv
verif/tb.sv
